### hdl/aop_pkg.sv
// ----------------------------------------------------------------------------
// Alpha-over blend package
// Shared widths, pipeline depths, pixel types and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package aop_pkg;

   localparam int PixW        = 8;
   localparam int ProdW       = 2 * PixW;
   localparam int BitsPerStage = 2;
   localparam int DivStages   = PixW / BitsPerStage;
   localparam int MixStages   = 2;
   localparam int SideDepth   = DivStages + MixStages;
   localparam int Latency     = 2 + SideDepth + 1;

   localparam logic [PixW-1:0] FullScale = 8'd255;

   typedef struct packed {
      logic [PixW-1:0] src_red;
      logic [PixW-1:0] src_green;
      logic [PixW-1:0] src_blue;
      logic [PixW-1:0] src_alpha;
      logic [PixW-1:0] dst_red;
      logic [PixW-1:0] dst_green;
      logic [PixW-1:0] dst_blue;
      logic [PixW-1:0] dst_alpha;
   } pix_type;

   typedef struct packed {
      pix_type         pix;
      logic [PixW-1:0] ap;
   } side_type;

   // Exact floor(x / 255) for any x up to 255 * 255.
   function automatic logic [PixW-1:0] div255(input logic [ProdW-1:0] x);
      logic [ProdW:0] t;
      t = {1'b0, x} + {{(PixW + 1){1'b0}}, x[ProdW-1:PixW]} + {{ProdW{1'b0}}, 1'b1};
      div255 = t[ProdW-1:PixW];
   endfunction

endpackage

### hdl/alpha_over_pixel_blend_top.sv
// ----------------------------------------------------------------------------
// Alpha-over pixel blend, top level
// rsp_strobe marks the result of each accepted start; one item is taken every cycle while busy is low.
// The weight divider (four stages) and the channel mixers set the depth.
// busy is high only during reset; reset clears the valid pipeline.
// The receiver cannot stall, so results leave on a fixed schedule.
// ----------------------------------------------------------------------------
module alpha_over_pixel_blend_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_src_red,
   input  logic [7:0] req_src_green,
   input  logic [7:0] req_src_blue,
   input  logic [7:0] req_src_alpha,
   input  logic [7:0] req_dst_red,
   input  logic [7:0] req_dst_green,
   input  logic [7:0] req_dst_blue,
   input  logic [7:0] req_dst_alpha,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_alpha,
   output logic       rsp_written
);

   localparam int W = aop_pkg::PixW;
   localparam int P = aop_pkg::ProdW;
   localparam int L = aop_pkg::Latency;
   localparam int D = aop_pkg::SideDepth;

   logic [L-1:0]        vld_ff, vld_in;
   aop_pkg::pix_type    pix1_ff, pix1_in;
   logic [P-1:0]        prod1_ff, prod1_in;
   logic [P-1:0]        num1_ff, num1_in;
   aop_pkg::pix_type    pix2_ff;
   logic [P-1:0]        num2_ff;
   logic [W-1:0]        ap2_ff, ap2_in;
   logic [W:0]          ap_sum;
   logic [W-1:0]        q255;
   aop_pkg::side_type   side_ff[D];
   aop_pkg::side_type   side_in[D];
   aop_pkg::side_type   tail;
   logic [W-1:0]        weight;
   logic [W-1:0]        mix_red, mix_green, mix_blue;
   logic [W-1:0]        out_red_ff, out_red_in;
   logic [W-1:0]        out_green_ff, out_green_in;
   logic [W-1:0]        out_blue_ff, out_blue_in;
   logic [W-1:0]        out_alpha_ff, out_alpha_in;
   logic                written_ff, written_in;

   assign busy = reset;

   always_comb begin
      vld_in = {vld_ff[L-2:0], start & ~busy};

      pix1_in.src_red   = req_src_red;
      pix1_in.src_green = req_src_green;
      pix1_in.src_blue  = req_src_blue;
      pix1_in.src_alpha = req_src_alpha;
      pix1_in.dst_red   = req_dst_red;
      pix1_in.dst_green = req_dst_green;
      pix1_in.dst_blue  = req_dst_blue;
      pix1_in.dst_alpha = req_dst_alpha;
      prod1_in = {{W{1'b0}}, req_dst_alpha} * {{W{1'b0}}, req_src_alpha};
      num1_in  = {req_src_alpha, {W{1'b0}}} - {{W{1'b0}}, req_src_alpha};

      q255   = aop_pkg::div255(prod1_ff);
      ap_sum = {1'b0, pix1_ff.dst_alpha} + {1'b0, pix1_ff.src_alpha} - {1'b0, q255};
      if (ap_sum > {1'b0, aop_pkg::FullScale}) begin
         ap2_in = aop_pkg::FullScale;
      end else begin
         ap2_in = ap_sum[W-1:0];
      end

      side_in[0].pix = pix2_ff;
      side_in[0].ap  = ap2_ff;
      for (int s = 1; s < D; s++) begin
         side_in[s] = side_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix1_ff  <= pix1_in;
      prod1_ff <= prod1_in;
      num1_ff  <= num1_in;
      pix2_ff  <= pix1_ff;
      num2_ff  <= num1_ff;
      ap2_ff   <= ap2_in;
      for (int s = 0; s < D; s++) begin
         side_ff[s] <= side_in[s];
      end
   end

   aop_wdiv u_wdiv (
      .clock  (clock),
      .num    (num2_ff),
      .den    (ap2_ff),
      .weight (weight)
   );

   aop_mix u_mix_red (
      .clock  (clock),
      .src    (side_ff[aop_pkg::DivStages-1].pix.src_red),
      .dst    (side_ff[aop_pkg::DivStages-1].pix.dst_red),
      .weight (weight),
      .mixed  (mix_red)
   );

   aop_mix u_mix_green (
      .clock  (clock),
      .src    (side_ff[aop_pkg::DivStages-1].pix.src_green),
      .dst    (side_ff[aop_pkg::DivStages-1].pix.dst_green),
      .weight (weight),
      .mixed  (mix_green)
   );

   aop_mix u_mix_blue (
      .clock  (clock),
      .src    (side_ff[aop_pkg::DivStages-1].pix.src_blue),
      .dst    (side_ff[aop_pkg::DivStages-1].pix.dst_blue),
      .weight (weight),
      .mixed  (mix_blue)
   );

   always_comb begin
      tail = side_ff[D-1];
      if (tail.pix.src_alpha == '0) begin
         out_red_in   = tail.pix.dst_red;
         out_green_in = tail.pix.dst_green;
         out_blue_in  = tail.pix.dst_blue;
         out_alpha_in = tail.pix.dst_alpha;
         written_in   = 1'b0;
      end else begin
         out_red_in   = mix_red;
         out_green_in = mix_green;
         out_blue_in  = mix_blue;
         out_alpha_in = tail.ap;
         written_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      out_alpha_ff <= out_alpha_in;
      written_ff   <= written_in;
   end

   assign rsp_strobe    = vld_ff[L-1];
   assign rsp_out_red   = out_red_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_out_alpha = out_alpha_ff;
   assign rsp_written   = written_ff;

`ifndef SYNTH
   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, aop_pkg::Latency))
      else $error("Result strobe without an item accepted at the pipeline depth.");

   a_written_tracks_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_written == ($past(req_src_alpha, aop_pkg::Latency) != 8'd0)))
      else $error("Written flag does not match the source alpha of its item.");

   a_pass_keeps_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_written) |->
         (rsp_out_alpha == $past(req_dst_alpha, aop_pkg::Latency)))
      else $error("Passed-through item lost its destination alpha.");

   a_blend_alpha_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_written) |->
         (rsp_out_alpha >= $past(req_src_alpha, aop_pkg::Latency) &&
          rsp_out_alpha >= $past(req_dst_alpha, aop_pkg::Latency)))
      else $error("Blended alpha fell below one of its input alphas.");
`endif

endmodule

### hdl/aop_wdiv.sv
// ----------------------------------------------------------------------------
// Source weight divider
// Pipelined restoring divider for floor(num / den), two quotient bits per
// stage, with the quotient clamped to full scale and a zero divisor giving 0.
// ----------------------------------------------------------------------------
module aop_wdiv (
   input  logic                                clock,
   input  logic [aop_pkg::ProdW-1:0]           num,
   input  logic [aop_pkg::PixW-1:0]            den,
   output logic [aop_pkg::PixW-1:0]            weight
);

   localparam int W = aop_pkg::PixW;
   localparam int S = aop_pkg::DivStages;

   logic [W-1:0] rem_ff [S];
   logic [W-1:0] quo_ff [S];
   logic [W-1:0] lo_ff  [S];
   logic [W-1:0] den_ff [S];
   logic         ovf_ff [S];
   logic         zero_ff[S];

   logic [W-1:0] rem_in [S];
   logic [W-1:0] quo_in [S];
   logic [W-1:0] lo_in  [S];

   logic [W-1:0] stage_rem [S];
   logic [W-1:0] stage_quo [S];
   logic [W-1:0] stage_lo  [S];
   logic [W-1:0] stage_den [S];
   logic         stage_ovf [S];
   logic         stage_zero[S];

   function automatic logic [W:0] div_step(input logic [W-1:0] rem, input logic nb,
                                           input logic [W-1:0] dv);
      logic [W:0] t;
      logic [W:0] diff;
      t    = {rem, nb};
      diff = t - {1'b0, dv};
      if (t >= {1'b0, dv}) begin
         div_step = {1'b1, diff[W-1:0]};
      end else begin
         div_step = {1'b0, t[W-1:0]};
      end
   endfunction

   always_comb begin
      stage_rem[0]  = num[2*W-1:W];
      stage_quo[0]  = '0;
      stage_lo[0]   = num[W-1:0];
      stage_den[0]  = den;
      stage_ovf[0]  = (num[2*W-1:W] >= den);
      stage_zero[0] = (den == '0);
      for (int s = 1; s < S; s++) begin
         stage_rem[s]  = rem_ff[s-1];
         stage_quo[s]  = quo_ff[s-1];
         stage_lo[s]   = lo_ff[s-1];
         stage_den[s]  = den_ff[s-1];
         stage_ovf[s]  = ovf_ff[s-1];
         stage_zero[s] = zero_ff[s-1];
      end
   end

   always_comb begin
      logic [W-1:0] r;
      logic [W-1:0] q;
      logic [W-1:0] lo;
      logic [W:0]   res;
      for (int s = 0; s < S; s++) begin
         r  = stage_rem[s];
         q  = stage_quo[s];
         lo = stage_lo[s];
         for (int b = 0; b < aop_pkg::BitsPerStage; b++) begin
            res = div_step(r, lo[W-1], stage_den[s]);
            q   = {q[W-2:0], res[W]};
            r   = res[W-1:0];
            lo  = {lo[W-2:0], 1'b0};
         end
         rem_in[s] = r;
         quo_in[s] = q;
         lo_in[s]  = lo;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < S; s++) begin
         rem_ff[s]  <= rem_in[s];
         quo_ff[s]  <= quo_in[s];
         lo_ff[s]   <= lo_in[s];
         den_ff[s]  <= stage_den[s];
         ovf_ff[s]  <= stage_ovf[s];
         zero_ff[s] <= stage_zero[s];
      end
   end

   always_comb begin
      if (zero_ff[S-1]) begin
         weight = '0;
      end else if (ovf_ff[S-1]) begin
         weight = aop_pkg::FullScale;
      end else begin
         weight = quo_ff[S-1];
      end
   end

endmodule

### hdl/aop_mix.sv
// ----------------------------------------------------------------------------
// Colour channel mixer
// Two register stages computing floor((src*w + dst*(255-w)) / 255).
// ----------------------------------------------------------------------------
module aop_mix (
   input  logic                      clock,
   input  logic [aop_pkg::PixW-1:0]  src,
   input  logic [aop_pkg::PixW-1:0]  dst,
   input  logic [aop_pkg::PixW-1:0]  weight,
   output logic [aop_pkg::PixW-1:0]  mixed
);

   localparam int W = aop_pkg::PixW;
   localparam int P = aop_pkg::ProdW;

   logic [P-1:0] ps_ff, ps_in;
   logic [P-1:0] pd_ff, pd_in;
   logic [P-1:0] sum_ff;
   logic [P:0]   sum_in;
   logic [W-1:0] inv_w;

   always_comb begin
      inv_w  = aop_pkg::FullScale - weight;
      ps_in  = {{W{1'b0}}, src} * {{W{1'b0}}, weight};
      pd_in  = {{W{1'b0}}, dst} * {{W{1'b0}}, inv_w};
      sum_in = {1'b0, ps_ff} + {1'b0, pd_ff};
   end

   always_ff @(posedge clock) begin
      ps_ff  <= ps_in;
      pd_ff  <= pd_in;
      sum_ff <= sum_in[P-1:0];
   end

   assign mixed = aop_pkg::div255(sum_ff);

endmodule
